[rtl/core/skv_pkg.sv]
// Shared types, codes and defaults for the slot key/value store.
package skv_pkg;

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 4;
    localparam int S_TDATA_W = KEY_W + VALUE_W;
    localparam int M_TDATA_W = ((VALUE_W + INDEX_W + 7) / 8) * 8;

    // Default sizing
    localparam int SLOT_COUNT_DEF = 15;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORGET = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[rtl/core/skv_ram.sv]
// Key/value slot memory: one write port, one registered read port.
module skv_ram #(
    parameter int DEPTH  = 15,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    import skv_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/slot_key_value_store_top.sv]
// Top level of the slot key/value store: command sequencer, used bits and result register.
//
// The store holds SLOT_COUNT slots, each a used bit and a key/value pair. Every
// command word (read, write, forget) gives exactly one result word. The pairs sit
// in a synchronous memory with a registered read; the sequencer walks the slots in
// order, one read issued per cycle, comparing the previous slot's key as the next
// is fetched, and noting the lowest free slot on the way. The walk stops at the
// first used slot with an equal key. A command therefore walks slots 0 to k when
// it matches slot k, and all SLOT_COUNT slots (15 at the default) when nothing
// matches; the walk is serial because of the single memory read port. Used bits
// are flip-flops and clear at reset, so no clearing pass is needed. Results are
// held in an output register, and a new command is taken in the same cycle that
// the previous result is loaded into it. Command code 3 does nothing and reports
// not_found. Keys and values wider than KEY_BITS or VALUE_BITS on the ports are
// truncated; slot_index gives the low four bits of the slot number.
module slot_key_value_store_top #(
    parameter int SLOT_COUNT = skv_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = skv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skv_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command words
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [63:0] key, [127:64] value
    input  logic [skv_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [skv_pkg::CMD_W-1:0]     i_s_axis_tuser,
    // result words
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [63:0] read_value, [67:64] slot_index, [71:68] zero
    output logic [skv_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [skv_pkg::STATUS_W-1:0]  o_m_axis_tuser
);
    import skv_pkg::*;

    // Address and counter widths; the counter must also hold SLOT_COUNT itself.
    localparam int AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int DATA_W = KEY_BITS + VALUE_BITS;

    // Sequencer state
    t_state r_state, n_state;

    // Latched command word
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Walk over the slots
    logic [CW-1:0]         r_issue_cnt;
    logic                  r_chk_vld;
    logic [AW-1:0]         r_chk_addr;
    logic                  r_rd_used;

    // Walk findings
    logic                  r_hit;
    logic [AW-1:0]         r_hit_addr;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic                  r_free_found;
    logic [AW-1:0]         r_free_addr;

    // Used bits, one per slot
    logic [SLOT_COUNT-1:0] r_used;

    // Result register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]    r_out_val;
    logic [INDEX_W-1:0]    r_out_idx;

    // Combinational controls
    logic                  s_acc;
    logic                  out_free;
    logic                  commit;
    logic                  issue_en;
    logic                  issue_done;
    logic                  scan_hit;
    logic                  scan_end;
    logic [DATA_W-1:0]     rd_data;

    logic                  ram_we;
    logic [DATA_W-1:0]     ram_wdata;
    logic                  used_clr;

    logic [STATUS_W-1:0]   res_status;
    logic [VALUE_W-1:0]    res_val;
    logic [AW-1:0]         res_addr;
    logic [31:0]           res_idx_wide;

    // ------------------------------------------------------------------
    // Slot memory: key in the low bits, value above it
    // ------------------------------------------------------------------
    assign ram_wdata = {r_value, r_key};

    skv_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (AW),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_addr),
        .i_wdata (ram_wdata),
        .i_re    (issue_en),
        .i_raddr (r_issue_cnt[AW-1:0]),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Handshake and walk control
    // ------------------------------------------------------------------
    always_comb begin
        out_free        = !r_out_valid || i_m_axis_tready;
        commit          = (r_state == S_DONE) && out_free;
        o_s_axis_tready = (r_state == S_IDLE) || commit;
        s_acc           = i_s_axis_tvalid && o_s_axis_tready;

        // The slot read last cycle is compared now; a used slot with an equal key wins.
        scan_hit   = (r_state == S_SCAN) && r_chk_vld && r_rd_used
                     && (rd_data[KEY_BITS-1:0] == r_key);
        issue_done = (r_issue_cnt == CW'(SLOT_COUNT));
        issue_en   = (r_state == S_SCAN) && !issue_done && !scan_hit;
        scan_end   = scan_hit || (issue_done && !r_chk_vld);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = s_acc ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result and table update, taken when the walk is over
    always_comb begin
        res_status = ST_NOT_FOUND;
        res_val    = '0;
        res_addr   = '0;
        ram_we     = 1'b0;
        used_clr   = 1'b0;
        unique case (r_cmd)
            CMD_READ: begin
                if (r_hit) begin
                    res_status = ST_OK;
                    res_val    = VALUE_W'(r_hit_val);
                    res_addr   = r_hit_addr;
                end
            end
            CMD_WRITE: begin
                if (r_hit) begin
                    res_status = ST_EXISTS;
                    res_addr   = r_hit_addr;
                end else if (r_free_found) begin
                    res_status = ST_OK;
                    res_addr   = r_free_addr;
                    ram_we     = commit;
                end else begin
                    res_status = ST_NO_SPACE;
                end
            end
            CMD_FORGET: begin
                if (r_hit) begin
                    res_status = ST_OK;
                    res_addr   = r_hit_addr;
                    used_clr   = commit;
                end
            end
            default: begin
                // unused command code: leave the table alone
                res_status = ST_NOT_FOUND;
            end
        endcase
        res_idx_wide = 32'(res_addr);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else begin
            r_state <= n_state;

            // Valid for the slot whose data arrives next cycle
            r_chk_vld <= issue_en;

            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (ram_we) begin
                r_used[r_free_addr] <= 1'b1;
            end
            if (used_clr) begin
                r_used[r_hit_addr] <= 1'b0;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd        <= i_s_axis_tuser;
            r_key        <= i_s_axis_tdata[KEY_BITS-1:0];
            r_value      <= i_s_axis_tdata[KEY_W +: VALUE_BITS];
            r_issue_cnt  <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (issue_en) begin
                r_issue_cnt <= r_issue_cnt + CW'(1);
                r_chk_addr  <= r_issue_cnt[AW-1:0];
                r_rd_used   <= r_used[r_issue_cnt[AW-1:0]];
            end
            // Hold the value now: the next read overwrites the memory output.
            if (scan_hit) begin
                r_hit      <= 1'b1;
                r_hit_addr <= r_chk_addr;
                r_hit_val  <= rd_data[KEY_BITS +: VALUE_BITS];
            end
            if ((r_state == S_SCAN) && r_chk_vld && !r_rd_used && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_addr  <= r_chk_addr;
            end
        end

        if (commit) begin
            r_out_status <= res_status;
            r_out_val    <= res_val;
            r_out_idx    <= res_idx_wide[INDEX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {(M_TDATA_W - VALUE_W - INDEX_W)'(0), r_out_idx, r_out_val};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new command always starts its walk at the first slot.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_SCAN) && (r_issue_cnt == '0) && !r_hit)
        else $error("walk did not restart after a command word");

    // A store never lands on a slot that is already in use.
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_used[r_free_addr])
        else $error("write targets a used slot");

    // A store marks its slot used.
    a_store_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_used[$past(r_free_addr)])
        else $error("stored slot not marked used");

    // A forget only clears a slot that was in use.
    a_forget_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_clr |-> r_used[r_hit_addr])
        else $error("forget on a slot that is not in use");

endmodule
